@@ src/aetp_pkg.sv @@
// shared types, codes and constants of the ansi escape terminal parser
package aetp_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int MAX_DIM_DEF    = 256;

  // configuration register indexes
  localparam logic [1:0] REG_COLS   = 2'd0;
  localparam logic [1:0] REG_ROWS   = 2'd1;
  localparam logic [1:0] REG_DEF_FG = 2'd2;
  localparam logic [1:0] REG_DEF_BG = 2'd3;

  localparam logic [8:0]  COLS_RST   = 9'd80;
  localparam logic [8:0]  ROWS_RST   = 9'd25;
  localparam logic [23:0] DEF_FG_RST = 24'hAAAAAA;
  localparam logic [23:0] DEF_BG_RST = 24'h000000;

  // result command codes
  localparam logic [2:0] CMD_GLYPH  = 3'd0;
  localparam logic [2:0] CMD_ERASE  = 3'd1;
  localparam logic [2:0] CMD_FILL   = 3'd2;
  localparam logic [2:0] CMD_SCROLL = 3'd3;
  localparam logic [2:0] CMD_CLRTOP = 3'd4;

  // parser states
  localparam logic [2:0] PS_NORMAL  = 3'd0;
  localparam logic [2:0] PS_ESC     = 3'd1;
  localparam logic [2:0] PS_CSI     = 3'd2;
  localparam logic [2:0] PS_HASH    = 3'd3;
  localparam logic [2:0] PS_CHARSET = 3'd4;

  // datapath operations issued by the controller
  localparam logic [3:0] DP_NOP       = 4'd0;
  localparam logic [3:0] DP_LATCH     = 4'd1;
  localparam logic [3:0] DP_EXEC      = 4'd2;
  localparam logic [3:0] DP_NEWLINE   = 4'd3;
  localparam logic [3:0] DP_SGR_START = 4'd4;
  localparam logic [3:0] DP_SGR_PARAM = 4'd5;
  localparam logic [3:0] DP_SGR_MODE  = 4'd6;
  localparam logic [3:0] DP_SGR_R     = 4'd7;
  localparam logic [3:0] DP_SGR_G     = 4'd8;
  localparam logic [3:0] DP_SGR_B     = 4'd9;
  localparam logic [3:0] DP_SGR_IDX   = 4'd10;
  localparam logic [3:0] DP_SGR_COL   = 4'd11;

  // byte codes
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_7       = 8'h37;
  localparam logic [7:0] CH_8       = 8'h38;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_FIN_LO  = 8'h40;
  localparam logic [7:0] CH_CUU     = 8'h41;
  localparam logic [7:0] CH_CUD     = 8'h42;
  localparam logic [7:0] CH_CUF     = 8'h43;
  localparam logic [7:0] CH_CUB     = 8'h44;
  localparam logic [7:0] CH_CUP     = 8'h48;
  localparam logic [7:0] CH_ED      = 8'h4A;
  localparam logic [7:0] CH_EL      = 8'h4B;
  localparam logic [7:0] CH_RI      = 8'h4D;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RIS     = 8'h63;
  localparam logic [7:0] CH_HVP     = 8'h66;
  localparam logic [7:0] CH_SGR     = 8'h6D;
  localparam logic [7:0] CH_SAVE    = 8'h73;
  localparam logic [7:0] CH_RESTORE = 8'h75;
  localparam logic [7:0] CH_FIN_HI  = 8'h7E;

  typedef struct packed {
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [23:0] def_fg;
    logic [23:0] def_bg;
  } cfg_t;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic exec_emit;
    logic exec_wrap;
    logic exec_sgr;
    logic nl_emit;
    logic walk_end;
    logic param_ext;
    logic mode_rgb;
    logic mode_idx;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [7:0]  end_row;
    logic [8:0]  end_col;
    logic [7:0]  glyph;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic        underline_on;
    logic        last;
  } out_beat_t;

endpackage

@@ src/aetp_cfg.sv @@
// configuration registers behind the apb-style port
module aetp_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output aetp_pkg::cfg_t       cfg,
  output logic                 geom_upd
);

  logic       wr_en;
  logic [1:0] wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols   <= aetp_pkg::COLS_RST;
      cfg.rows   <= aetp_pkg::ROWS_RST;
      cfg.def_fg <= aetp_pkg::DEF_FG_RST;
      cfg.def_bg <= aetp_pkg::DEF_BG_RST;
      geom_upd   <= 1'b0;
    end else begin
      // cursor clamp runs the cycle after a geometry write
      geom_upd <= wr_en && (wr_idx == aetp_pkg::REG_COLS || wr_idx == aetp_pkg::REG_ROWS);
      if (wr_en) begin
        case (wr_idx)
          aetp_pkg::REG_COLS:   cfg.cols   <= pwdata[8:0];
          aetp_pkg::REG_ROWS:   cfg.rows   <= pwdata[8:0];
          aetp_pkg::REG_DEF_FG: cfg.def_fg <= pwdata[23:0];
          aetp_pkg::REG_DEF_BG: cfg.def_bg <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (wr_idx)
      aetp_pkg::REG_COLS:   prdata = {23'd0, cfg.cols};
      aetp_pkg::REG_ROWS:   prdata = {23'd0, cfg.rows};
      aetp_pkg::REG_DEF_FG: prdata = {8'd0, cfg.def_fg};
      aetp_pkg::REG_DEF_BG: prdata = {8'd0, cfg.def_bg};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

@@ src/aetp_datapath.sv @@
// parser datapath: cursor, attributes, csi parameters, palette and result register
module aetp_datapath #(
  parameter int MAX_PARAMS = aetp_pkg::MAX_PARAMS_DEF,
  parameter int MAX_DIM    = aetp_pkg::MAX_DIM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aetp_pkg::cfg_t       cfg,
  input  logic                 geom_upd,
  input  logic                 req_type,
  input  logic [7:0]           data_byte,
  input  logic [3:0]           pal_index,
  input  logic [23:0]          pal_color,
  input  aetp_pkg::dp_cmd_t    dcmd,
  output aetp_pkg::dp_stat_t   stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output aetp_pkg::out_beat_t  out_beat
);

  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam int IW = CW + 1;
  localparam int AW = $clog2(MAX_PARAMS);
  localparam int DW = $clog2(MAX_DIM);
  localparam int EW = $clog2(MAX_DIM + 1);
  localparam int SW = 18;

  // latched item
  logic        req_r;
  logic [7:0]  byte_r;
  logic [3:0]  pidx_r;
  logic [23:0] pcol_r;

  // parser state
  logic [2:0]    pstate;
  logic [15:0]   pval [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] pset;
  logic [CW-1:0] pcount;
  logic          pseen;
  logic [DW-1:0] ccol, crow, scol, srow;
  logic [23:0]   cur_fg, cur_bg;
  logic          bold, under, rev;
  logic [23:0]   palette [16];

  // sgr walk
  logic [IW-1:0] walk;
  logic          ext_bg;
  logic [7:0]    tr, tg, sidx;
  logic [2:0]    q36;

  // geometry
  logic [EW-1:0] cols, rows;
  logic [SW-1:0] col_w, row_w, cols_w, rows_w, lim_col, lim_row;

  function automatic logic [EW-1:0] eff_dim(input logic [8:0] v);
    if (v == 9'd0) return EW'(1);
    else if (32'(v) > 32'(MAX_DIM)) return EW'(MAX_DIM);
    else return EW'(v);
  endfunction

  function automatic logic [SW-1:0] clampv(input logic [SW-1:0] v, input logic [SW-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [7:0] lighten(input logic [7:0] ch);
    return (ch > 8'hAA) ? 8'hFF : ch + 8'h55;
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] cube_lv(input logic [2:0] v);
    return (v == 3'd0) ? 8'd0 : 8'd55 + 8'(v) * 8'd40;
  endfunction

  function automatic aetp_pkg::out_beat_t mk_beat(
    input logic [2:0] c, input logic [SW-1:0] r0, input logic [SW-1:0] c0,
    input logic [SW-1:0] r1, input logic [SW-1:0] c1, input logic [7:0] g,
    input logic [23:0] f, input logic [23:0] b, input logic ul, input logic lst);
    aetp_pkg::out_beat_t o;
    o.cmd          = c;
    o.row          = r0[7:0];
    o.col          = c0[7:0];
    o.end_row      = r1[7:0];
    o.end_col      = c1[8:0];
    o.glyph        = g;
    o.fg_color     = f;
    o.bg_color     = b;
    o.underline_on = ul;
    o.last         = lst;
    return o;
  endfunction

  assign cols    = eff_dim(cfg.cols);
  assign rows    = eff_dim(cfg.rows);
  assign col_w   = SW'(ccol);
  assign row_w   = SW'(crow);
  assign cols_w  = SW'(cols);
  assign rows_w  = SW'(rows);
  assign lim_col = cols_w - SW'(1);
  assign lim_row = rows_w - SW'(1);

  // new line shared by lf, tab, wrap
  logic                nl_scroll;
  logic [DW-1:0]       nl_row;
  aetp_pkg::out_beat_t scroll_beat;

  assign nl_scroll   = (row_w + SW'(1)) >= rows_w;
  assign nl_row      = nl_scroll ? DW'(lim_row) : DW'(row_w + SW'(1));
  assign scroll_beat = mk_beat(aetp_pkg::CMD_SCROLL, '0, '0, '0, '0, 8'd0, 24'd0,
                               cfg.def_bg, 1'b0, 1'b1);

  // csi parameter views for the final byte
  logic [CW-1:0] pcnt_fin;
  logic          p0_has, p1_has;
  logic [15:0]   cnt, mode, trow, tcol;

  assign pcnt_fin = (pseen || pcount != '0) ? pcount + CW'(1) : pcount;
  assign p0_has   = (pcnt_fin > CW'(0)) && pset[0];
  assign p1_has   = (pcnt_fin > CW'(1)) && pset[1];
  assign cnt      = (!p0_has || pval[0] == 16'd0) ? 16'd1 : pval[0];
  assign mode     = p0_has ? pval[0] : 16'd0;
  assign trow     = (p0_has && pval[0] != 16'd0) ? pval[0] - 16'd1 : 16'd0;
  assign tcol     = (p1_has && pval[1] != 16'd0) ? pval[1] - 16'd1 : 16'd0;

  // digit accumulation
  logic          ci_ok;
  logic [AW-1:0] ci;
  logic [15:0]   acc_cur, acc_sat;
  logic [19:0]   acc;

  assign ci_ok   = pcount < CW'(MAX_PARAMS);
  assign ci      = pcount[AW-1:0];
  assign acc_cur = (ci_ok && pset[ci]) ? pval[ci] : 16'd0;
  assign acc     = 20'(acc_cur) * 20'd10 + 20'(byte_r - aetp_pkg::CH_0);
  assign acc_sat = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];

  // glyph colours
  logic [23:0] gf, gb, gf_bold;
  assign gf      = rev ? cur_bg : cur_fg;
  assign gb      = rev ? cur_fg : cur_bg;
  assign gf_bold = bold ? {lighten(gf[23:16]), lighten(gf[15:8]), lighten(gf[7:0])} : gf;

  logic [SW-1:0] tab_w;
  assign tab_w = (col_w + SW'(8)) & ~SW'(7);

  // execution of one byte or palette write
  logic [2:0]          ex_pstate;
  logic [DW-1:0]       ex_col, ex_row, ex_scol, ex_srow;
  logic [23:0]         ex_fg, ex_bg;
  logic                ex_bold, ex_under, ex_rev;
  logic [CW-1:0]       ex_pcount;
  logic                ex_pseen, ex_clr, ex_pw, ex_palw;
  logic                ex_emit, ex_wrap, ex_sgr;
  aetp_pkg::out_beat_t ex_beat;

  always_comb begin
    ex_pstate = pstate;
    ex_col    = ccol;
    ex_row    = crow;
    ex_scol   = scol;
    ex_srow   = srow;
    ex_fg     = cur_fg;
    ex_bg     = cur_bg;
    ex_bold   = bold;
    ex_under  = under;
    ex_rev    = rev;
    ex_pcount = pcount;
    ex_pseen  = pseen;
    ex_clr    = 1'b0;
    ex_pw     = 1'b0;
    ex_palw   = 1'b0;
    ex_emit   = 1'b0;
    ex_wrap   = 1'b0;
    ex_sgr    = 1'b0;
    ex_beat   = scroll_beat;
    if (req_r) begin
      ex_palw = 1'b1;
    end else begin
      case (pstate)
        aetp_pkg::PS_NORMAL: begin
          if (byte_r == aetp_pkg::CH_ESC) begin
            ex_pstate = aetp_pkg::PS_ESC;
          end else if (byte_r == aetp_pkg::CH_CR) begin
            ex_col = '0;
          end else if (byte_r == aetp_pkg::CH_LF) begin
            ex_row  = nl_row;
            ex_emit = nl_scroll;
          end else if (byte_r == aetp_pkg::CH_TAB) begin
            if (tab_w >= cols_w) begin
              ex_col  = '0;
              ex_row  = nl_row;
              ex_emit = nl_scroll;
            end else begin
              ex_col = DW'(tab_w);
            end
          end else if (byte_r == aetp_pkg::CH_BS) begin
            if (ccol != '0) ex_col = ccol - DW'(1);
          end else if (byte_r >= aetp_pkg::CH_SPACE) begin
            ex_emit = 1'b1;
            ex_beat = mk_beat(aetp_pkg::CMD_GLYPH, row_w, col_w, '0, '0, byte_r,
                              gf_bold, gb, under, 1'b1);
            if ((col_w + SW'(1)) >= cols_w) begin
              ex_col  = '0;
              ex_wrap = 1'b1;
              // a scroll follows the glyph when the wrap leaves the last row
              ex_beat.last = !nl_scroll;
            end else begin
              ex_col = ccol + DW'(1);
            end
          end
        end
        aetp_pkg::PS_ESC: begin
          ex_pstate = aetp_pkg::PS_NORMAL;
          case (byte_r)
            aetp_pkg::CH_LBRACK: begin
              ex_clr    = 1'b1;
              ex_pcount = '0;
              ex_pseen  = 1'b0;
              ex_pstate = aetp_pkg::PS_CSI;
            end
            aetp_pkg::CH_7: begin
              ex_scol = ccol;
              ex_srow = crow;
            end
            aetp_pkg::CH_8: begin
              ex_col = DW'(clampv(SW'(scol), lim_col));
              ex_row = DW'(clampv(SW'(srow), lim_row));
            end
            aetp_pkg::CH_RI: begin
              if (crow == '0) begin
                ex_emit = 1'b1;
                ex_beat = scroll_beat;
                ex_beat.cmd = aetp_pkg::CMD_CLRTOP;
              end else begin
                ex_row = crow - DW'(1);
              end
            end
            aetp_pkg::CH_RIS: begin
              ex_fg    = cfg.def_fg;
              ex_bg    = cfg.def_bg;
              ex_bold  = 1'b0;
              ex_under = 1'b0;
              ex_rev   = 1'b0;
              ex_emit  = 1'b1;
              ex_beat  = scroll_beat;
              ex_beat.cmd = aetp_pkg::CMD_FILL;
              ex_col   = '0;
              ex_row   = '0;
            end
            aetp_pkg::CH_HASH:   ex_pstate = aetp_pkg::PS_HASH;
            aetp_pkg::CH_LPAREN,
            aetp_pkg::CH_RPAREN: ex_pstate = aetp_pkg::PS_CHARSET;
            default: ;
          endcase
        end
        aetp_pkg::PS_CSI: begin
          if (byte_r inside {[aetp_pkg::CH_0:aetp_pkg::CH_9]}) begin
            if (ci_ok) begin
              ex_pw    = 1'b1;
              ex_pseen = 1'b1;
            end
          end else if (byte_r == aetp_pkg::CH_SEMI) begin
            if (pcount < CW'(MAX_PARAMS - 1)) ex_pcount = pcount + CW'(1);
            ex_pseen = 1'b0;
          end else if (byte_r inside {aetp_pkg::CH_QUEST, aetp_pkg::CH_GT,
                                      aetp_pkg::CH_LT, aetp_pkg::CH_BANG}) begin
            ex_pstate = pstate;
          end else if (byte_r inside {[aetp_pkg::CH_FIN_LO:aetp_pkg::CH_FIN_HI]}) begin
            ex_pcount = pcnt_fin;
            ex_pstate = aetp_pkg::PS_NORMAL;
            case (byte_r)
              aetp_pkg::CH_CUU:
                ex_row = (row_w >= SW'(cnt)) ? DW'(row_w - SW'(cnt)) : '0;
              aetp_pkg::CH_CUD:
                ex_row = DW'(clampv(row_w + SW'(cnt), lim_row));
              aetp_pkg::CH_CUF:
                ex_col = DW'(clampv(col_w + SW'(cnt), lim_col));
              aetp_pkg::CH_CUB:
                ex_col = (col_w >= SW'(cnt)) ? DW'(col_w - SW'(cnt)) : '0;
              aetp_pkg::CH_CUP,
              aetp_pkg::CH_HVP: begin
                ex_row = DW'(clampv(SW'(trow), lim_row));
                ex_col = DW'(clampv(SW'(tcol), lim_col));
              end
              aetp_pkg::CH_ED: begin
                ex_emit = 1'b1;
                if (mode == 16'd0) begin
                  ex_beat = mk_beat(aetp_pkg::CMD_ERASE, row_w, col_w, lim_row, cols_w,
                                    aetp_pkg::CH_SPACE, cur_fg, cur_bg, 1'b0, 1'b1);
                end else if (mode == 16'd1) begin
                  ex_beat = mk_beat(aetp_pkg::CMD_ERASE, '0, '0, row_w, col_w + SW'(1),
                                    aetp_pkg::CH_SPACE, cur_fg, cur_bg, 1'b0, 1'b1);
                end else begin
                  ex_beat = scroll_beat;
                  ex_beat.cmd = aetp_pkg::CMD_FILL;
                  ex_col = '0;
                  ex_row = '0;
                end
              end
              aetp_pkg::CH_EL: begin
                ex_emit = 1'b1;
                if (mode == 16'd0) begin
                  ex_beat = mk_beat(aetp_pkg::CMD_ERASE, row_w, col_w, row_w, cols_w,
                                    aetp_pkg::CH_SPACE, cur_fg, cur_bg, 1'b0, 1'b1);
                end else if (mode == 16'd1) begin
                  ex_beat = mk_beat(aetp_pkg::CMD_ERASE, row_w, '0, row_w, col_w + SW'(1),
                                    aetp_pkg::CH_SPACE, cur_fg, cur_bg, 1'b0, 1'b1);
                end else begin
                  ex_beat = mk_beat(aetp_pkg::CMD_ERASE, row_w, '0, row_w, cols_w,
                                    aetp_pkg::CH_SPACE, cur_fg, cur_bg, 1'b0, 1'b1);
                end
              end
              aetp_pkg::CH_SGR: ex_sgr = 1'b1;
              aetp_pkg::CH_SAVE: begin
                ex_scol = ccol;
                ex_srow = crow;
              end
              aetp_pkg::CH_RESTORE: begin
                ex_col = DW'(clampv(SW'(scol), lim_col));
                ex_row = DW'(clampv(SW'(srow), lim_row));
              end
              default: ;
            endcase
          end else begin
            ex_pstate = aetp_pkg::PS_NORMAL;
          end
        end
        default: ex_pstate = aetp_pkg::PS_NORMAL;
      endcase
    end
  end

  // sgr parameter read port
  logic [IW-1:0] rd_off, rd_idx;
  logic          rd_has;
  logic [15:0]   rd_p;

  always_comb begin
    case (dcmd.op)
      aetp_pkg::DP_SGR_MODE: rd_off = IW'(1);
      aetp_pkg::DP_SGR_R,
      aetp_pkg::DP_SGR_IDX:  rd_off = IW'(2);
      aetp_pkg::DP_SGR_G:    rd_off = IW'(3);
      aetp_pkg::DP_SGR_B:    rd_off = IW'(4);
      default:               rd_off = IW'(0);
    endcase
  end

  assign rd_idx = walk + rd_off;
  assign rd_has = (rd_idx < IW'(pcount)) && pset[rd_idx[AW-1:0]];
  assign rd_p   = rd_has ? pval[rd_idx[AW-1:0]] : 16'd0;

  // per-parameter sgr decode
  logic [3:0]  sg_pa, pal_addr;
  logic [23:0] pal_rd;
  logic        sg_ext;

  always_comb begin
    sg_pa = 4'd0;
    if (rd_p inside {[16'd30:16'd37]})        sg_pa = 4'(rd_p - 16'd30);
    else if (rd_p inside {[16'd40:16'd47]})   sg_pa = 4'(rd_p - 16'd40);
    else if (rd_p inside {[16'd90:16'd97]})   sg_pa = 4'(rd_p - 16'd82);
    else if (rd_p inside {[16'd100:16'd107]}) sg_pa = 4'(rd_p - 16'd92);
  end

  assign pal_addr = (dcmd.op == aetp_pkg::DP_SGR_COL) ? sidx[3:0] : sg_pa;
  assign pal_rd   = palette[pal_addr];
  assign sg_ext   = (rd_p == 16'd38) || (rd_p == 16'd48);

  // 256-colour expansion, split over two steps
  logic [7:0]  idx_n, cx;
  logic [13:0] q_prod;
  logic [5:0]  r36;
  logic [8:0]  g_prod;
  logic [2:0]  g6, b6;
  logic [7:0]  grey;
  logic [23:0] c256;

  assign idx_n  = sat8(rd_p);
  assign q_prod = 14'(8'(idx_n - 8'd16)) * 14'd57;
  assign cx     = sidx - 8'd16;
  assign r36    = 6'(cx - 8'(q36) * 8'd36);
  assign g_prod = 9'(14'(r36) * 14'd43 >> 8);
  assign g6     = g_prod[2:0];
  assign b6     = 3'(r36 - 6'(g6) * 6'd6);
  assign grey   = 8'd8 + (sidx - 8'd232) * 8'd10;

  always_comb begin
    if (sidx < 8'd16)       c256 = pal_rd;
    else if (sidx >= 8'd232) c256 = {grey, grey, grey};
    else                     c256 = {cube_lv(q36), cube_lv(g6), cube_lv(b6)};
  end

  logic push;
  assign push = (dcmd.op == aetp_pkg::DP_EXEC && ex_emit) ||
                (dcmd.op == aetp_pkg::DP_NEWLINE && nl_scroll);

  assign stat.out_busy  = out_valid;
  assign stat.exec_emit = ex_emit;
  assign stat.exec_wrap = ex_wrap;
  assign stat.exec_sgr  = ex_sgr;
  assign stat.nl_emit   = nl_scroll;
  assign stat.walk_end  = walk >= IW'(pcount);
  assign stat.param_ext = sg_ext;
  assign stat.mode_rgb  = rd_has && rd_p == 16'd2 && (walk + IW'(4)) < IW'(pcount);
  assign stat.mode_idx  = rd_has && rd_p == 16'd5 && (walk + IW'(2)) < IW'(pcount);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= aetp_pkg::PS_NORMAL;
      pset      <= '0;
      pcount    <= '0;
      pseen     <= 1'b0;
      ccol      <= '0;
      crow      <= '0;
      scol      <= '0;
      srow      <= '0;
      cur_fg    <= aetp_pkg::DEF_FG_RST;
      cur_bg    <= aetp_pkg::DEF_BG_RST;
      bold      <= 1'b0;
      under     <= 1'b0;
      rev       <= 1'b0;
      walk      <= '0;
      ext_bg    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (push) out_valid <= 1'b1;
      if (geom_upd) begin
        ccol <= DW'(clampv(col_w, lim_col));
        crow <= DW'(clampv(row_w, lim_row));
      end
      case (dcmd.op)
        aetp_pkg::DP_EXEC: begin
          pstate <= ex_pstate;
          pcount <= ex_pcount;
          pseen  <= ex_pseen;
          ccol   <= ex_col;
          crow   <= ex_row;
          scol   <= ex_scol;
          srow   <= ex_srow;
          cur_fg <= ex_fg;
          cur_bg <= ex_bg;
          bold   <= ex_bold;
          under  <= ex_under;
          rev    <= ex_rev;
          if (ex_clr) pset <= '0;
          if (ex_pw) pset[ci] <= 1'b1;
        end
        aetp_pkg::DP_NEWLINE: crow <= nl_row;
        aetp_pkg::DP_SGR_START: begin
          walk <= '0;
          if (pcount == '0) begin
            cur_fg <= cfg.def_fg;
            cur_bg <= cfg.def_bg;
            bold   <= 1'b0;
            under  <= 1'b0;
            rev    <= 1'b0;
          end
        end
        aetp_pkg::DP_SGR_PARAM: begin
          ext_bg <= (rd_p == 16'd48);
          if (!sg_ext) walk <= walk + IW'(1);
          if (rd_p == 16'd0) begin
            cur_fg <= cfg.def_fg;
            cur_bg <= cfg.def_bg;
            bold   <= 1'b0;
            under  <= 1'b0;
            rev    <= 1'b0;
          end else if (rd_p == 16'd1) bold <= 1'b1;
          else if (rd_p == 16'd4) under <= 1'b1;
          else if (rd_p == 16'd7) rev <= 1'b1;
          else if (rd_p == 16'd21 || rd_p == 16'd22) bold <= 1'b0;
          else if (rd_p == 16'd24) under <= 1'b0;
          else if (rd_p == 16'd27) rev <= 1'b0;
          else if (rd_p == 16'd39) cur_fg <= cfg.def_fg;
          else if (rd_p == 16'd49) cur_bg <= cfg.def_bg;
          else if (rd_p inside {[16'd30:16'd37], [16'd90:16'd97]}) cur_fg <= pal_rd;
          else if (rd_p inside {[16'd40:16'd47], [16'd100:16'd107]}) cur_bg <= pal_rd;
        end
        aetp_pkg::DP_SGR_MODE: begin
          if (!stat.mode_rgb && !stat.mode_idx) walk <= walk + IW'(1);
        end
        aetp_pkg::DP_SGR_B: begin
          walk <= walk + IW'(5);
          if (ext_bg) cur_bg <= {tr, tg, sat8(rd_p)};
          else        cur_fg <= {tr, tg, sat8(rd_p)};
        end
        aetp_pkg::DP_SGR_COL: begin
          walk <= walk + IW'(3);
          if (ext_bg) cur_bg <= c256;
          else        cur_fg <= c256;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (dcmd.op == aetp_pkg::DP_LATCH) begin
      req_r  <= req_type;
      byte_r <= data_byte;
      pidx_r <= pal_index;
      pcol_r <= pal_color;
    end
    if (dcmd.op == aetp_pkg::DP_EXEC && ex_palw) palette[pidx_r] <= pcol_r;
    if (dcmd.op == aetp_pkg::DP_EXEC && ex_pw) pval[ci] <= acc_sat;
    if (dcmd.op == aetp_pkg::DP_SGR_R) tr <= sat8(rd_p);
    if (dcmd.op == aetp_pkg::DP_SGR_G) tg <= sat8(rd_p);
    if (dcmd.op == aetp_pkg::DP_SGR_IDX) begin
      sidx <= idx_n;
      q36  <= q_prod[13:11];
    end
    if (push) out_beat <= (dcmd.op == aetp_pkg::DP_EXEC) ? ex_beat : scroll_beat;
  end

endmodule

@@ src/aetp_ctrl.sv @@
// controller state machine sequencing the parser datapath
module aetp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  aetp_pkg::dp_stat_t  stat,
  output aetp_pkg::dp_cmd_t   dcmd
);

  localparam logic [3:0] C_IDLE      = 4'd0;
  localparam logic [3:0] C_EXEC      = 4'd1;
  localparam logic [3:0] C_NL        = 4'd2;
  localparam logic [3:0] C_SGR_START = 4'd3;
  localparam logic [3:0] C_SGR_PARAM = 4'd4;
  localparam logic [3:0] C_SGR_MODE  = 4'd5;
  localparam logic [3:0] C_SGR_R     = 4'd6;
  localparam logic [3:0] C_SGR_G     = 4'd7;
  localparam logic [3:0] C_SGR_B     = 4'd8;
  localparam logic [3:0] C_SGR_IDX   = 4'd9;
  localparam logic [3:0] C_SGR_COL   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    dcmd.op    = aetp_pkg::DP_NOP;
    in_ready   = (state == C_IDLE);
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          dcmd.op    = aetp_pkg::DP_LATCH;
          state_next = C_EXEC;
        end
      end
      C_EXEC: begin
        // a byte that emits holds until the result register is free
        if (!(stat.exec_emit && stat.out_busy)) begin
          dcmd.op = aetp_pkg::DP_EXEC;
          if (stat.exec_sgr)       state_next = C_SGR_START;
          else if (stat.exec_wrap) state_next = C_NL;
          else                     state_next = C_IDLE;
        end
      end
      C_NL: begin
        if (!(stat.nl_emit && stat.out_busy)) begin
          dcmd.op    = aetp_pkg::DP_NEWLINE;
          state_next = C_IDLE;
        end
      end
      C_SGR_START: begin
        dcmd.op    = aetp_pkg::DP_SGR_START;
        state_next = C_SGR_PARAM;
      end
      C_SGR_PARAM: begin
        if (stat.walk_end) begin
          state_next = C_IDLE;
        end else begin
          dcmd.op = aetp_pkg::DP_SGR_PARAM;
          if (stat.param_ext) state_next = C_SGR_MODE;
        end
      end
      C_SGR_MODE: begin
        dcmd.op = aetp_pkg::DP_SGR_MODE;
        if (stat.mode_rgb)      state_next = C_SGR_R;
        else if (stat.mode_idx) state_next = C_SGR_IDX;
        else                    state_next = C_SGR_PARAM;
      end
      C_SGR_R: begin
        dcmd.op    = aetp_pkg::DP_SGR_R;
        state_next = C_SGR_G;
      end
      C_SGR_G: begin
        dcmd.op    = aetp_pkg::DP_SGR_G;
        state_next = C_SGR_B;
      end
      C_SGR_B: begin
        dcmd.op    = aetp_pkg::DP_SGR_B;
        state_next = C_SGR_PARAM;
      end
      C_SGR_IDX: begin
        dcmd.op    = aetp_pkg::DP_SGR_IDX;
        state_next = C_SGR_COL;
      end
      C_SGR_COL: begin
        dcmd.op    = aetp_pkg::DP_SGR_COL;
        state_next = C_SGR_PARAM;
      end
      default: state_next = C_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_exec_slot: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == aetp_pkg::DP_EXEC && stat.exec_emit) |-> !stat.out_busy)
    else $error("byte executed while result register full");

  a_nl_slot: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == aetp_pkg::DP_NEWLINE && stat.nl_emit) |-> !stat.out_busy)
    else $error("scroll issued while result register full");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (dcmd.op == aetp_pkg::DP_SGR_PARAM) |-> !stat.walk_end)
    else $error("sgr walk read past parameter count");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (state == C_IDLE))
    else $error("controller not idle after reset");
`endif

endmodule

@@ src/ansi_escape_terminal_parser.sv @@
// ansi escape terminal parser: a byte or palette write is latched, executed, and the
// controller returns to idle; a glyph that wraps the line adds a new-line step, and an sgr
// final byte adds a walk over the parameters (sgr sequencer, one param port), with extra
// steps per 38/48 form; no item is taken before idle; a byte that emits waits while a result
// sits in the one-beat output register, and the next item is accepted while that result waits
// synchronous active-high reset returns parser, cursor and attributes to power-up values
module ansi_escape_terminal_parser #(
  parameter int MAX_PARAMS = aetp_pkg::MAX_PARAMS_DEF,
  parameter int MAX_DIM    = aetp_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  pal_index,
  input  logic [23:0] pal_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  cmd,
  output logic [7:0]  row,
  output logic [7:0]  col,
  output logic [7:0]  end_row,
  output logic [8:0]  end_col,
  output logic [7:0]  glyph,
  output logic [23:0] fg_color,
  output logic [23:0] bg_color,
  output logic        underline_on,
  output logic        last
);

  aetp_pkg::cfg_t      cfg;
  logic                geom_upd;
  aetp_pkg::dp_cmd_t   dcmd;
  aetp_pkg::dp_stat_t  stat;
  aetp_pkg::out_beat_t beat;

  aetp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .geom_upd (geom_upd)
  );

  aetp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .dcmd     (dcmd)
  );

  aetp_datapath #(
    .MAX_PARAMS (MAX_PARAMS),
    .MAX_DIM    (MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .geom_upd  (geom_upd),
    .req_type  (req_type),
    .data_byte (data_byte),
    .pal_index (pal_index),
    .pal_color (pal_color),
    .dcmd      (dcmd),
    .stat      (stat),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_beat  (beat)
  );

  assign cmd          = beat.cmd;
  assign row          = beat.row;
  assign col          = beat.col;
  assign end_row      = beat.end_row;
  assign end_col      = beat.end_col;
  assign glyph        = beat.glyph;
  assign fg_color     = beat.fg_color;
  assign bg_color     = beat.bg_color;
  assign underline_on = beat.underline_on;
  assign last         = beat.last;

endmodule

@@ tb/aetp_checker.sv @@
// checker: predicts parser commands from accepted items and compares the output stream
`timescale 1ns / 100ps
module aetp_checker
  import aetp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  pal_index,
  input  logic [23:0] pal_color,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  row,
  input  logic [7:0]  col,
  input  logic [7:0]  end_row,
  input  logic [8:0]  end_col,
  input  logic [7:0]  glyph,
  input  logic [23:0] fg_color,
  input  logic [23:0] bg_color,
  input  logic        underline_on,
  input  logic        last,
  output int          fails,
  output int          pending,
  output int          beats
);

  logic [8:0]  scr_cols, scr_rows;
  logic [23:0] dflt_fg, dflt_bg;
  logic [2:0]  pstate;
  int          prm[MAX_PARAMS_DEF];
  int          pcnt;
  bit          pseen;
  int          cur_col, cur_row, sav_col, sav_row;
  logic [23:0] pen_fg, pen_bg;
  bit          bold, uline, rvs;
  logic [23:0] pal[16];
  out_beat_t   cmd_q[$];
  out_beat_t   step_q[$];

  function automatic int dim(logic [8:0] v);
    if (v < 1) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  function automatic void clamp_cursor();
    if (cur_col >= dim(scr_cols)) cur_col = dim(scr_cols) - 1;
    if (cur_row >= dim(scr_rows)) cur_row = dim(scr_rows) - 1;
  endfunction

  function automatic void put(logic [2:0] c, int r, int cl, int er, int ec, int g,
                              logic [23:0] f, logic [23:0] b, bit u);
    out_beat_t o;
    if (step_q.size() >= 2) return;
    o.cmd = c;
    o.row = r[7:0];
    o.col = cl[7:0];
    o.end_row = er[7:0];
    o.end_col = ec[8:0];
    o.glyph = g[7:0];
    o.fg_color = f;
    o.bg_color = b;
    o.underline_on = u;
    o.last = 1'b0;
    step_q.push_back(o);
  endfunction

  function automatic void new_line();
    cur_row++;
    if (cur_row >= dim(scr_rows)) begin
      put(CMD_SCROLL, 0, 0, 0, 0, 0, 24'h0, dflt_bg, 1'b0);
      cur_row = dim(scr_rows) - 1;
    end
  endfunction

  function automatic void reset_pen();
    pen_fg = dflt_fg;
    pen_bg = dflt_bg;
    bold = 0;
    uline = 0;
    rvs = 0;
  endfunction

  function automatic void clear_params();
    foreach (prm[i]) prm[i] = -1;
    pcnt = 0;
    pseen = 0;
  endfunction

  function automatic int param(int i, int def);
    if (i >= pcnt || i >= MAX_PARAMS_DEF) return def;
    return prm[i] < 0 ? def : prm[i];
  endfunction

  function automatic logic [7:0] sat8(int v);
    return v > 255 ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] cube(int v);
    int l;
    l = v ? 55 + v * 40 : 0;
    return l[7:0];
  endfunction

  function automatic logic [23:0] indexed_color(int p);
    int idx, g;
    idx = p > 255 ? 255 : p;
    if (idx < 16) return pal[idx];
    if (idx >= 232) begin
      g = 8 + (idx - 232) * 10;
      return {g[7:0], g[7:0], g[7:0]};
    end
    idx -= 16;
    return {cube(idx / 36), cube((idx % 36) / 6), cube(idx % 6)};
  endfunction

  // 38/48 forms; returns how many extra params were eaten
  function automatic int ext_color(int i, inout logic [23:0] dst);
    int mode;
    mode = param(i + 1, -1);
    if (mode == 2 && i + 4 < pcnt) begin
      dst = {sat8(param(i + 2, 0)), sat8(param(i + 3, 0)), sat8(param(i + 4, 0))};
      return 4;
    end
    if (mode == 5 && i + 2 < pcnt) begin
      dst = indexed_color(param(i + 2, 0));
      return 2;
    end
    return 0;
  endfunction

  function automatic void run_sgr();
    int i, p;
    i = 0;
    if (pcnt == 0) reset_pen();
    while (i < pcnt) begin
      p = param(i, 0);
      if (p == 0) reset_pen();
      else if (p == 1) bold = 1;
      else if (p == 4) uline = 1;
      else if (p == 7) rvs = 1;
      else if (p == 21 || p == 22) bold = 0;
      else if (p == 24) uline = 0;
      else if (p == 27) rvs = 0;
      else if (p >= 30 && p <= 37) pen_fg = pal[p - 30];
      else if (p == 38) i += ext_color(i, pen_fg);
      else if (p == 39) pen_fg = dflt_fg;
      else if (p >= 40 && p <= 47) pen_bg = pal[p - 40];
      else if (p == 48) i += ext_color(i, pen_bg);
      else if (p == 49) pen_bg = dflt_bg;
      else if (p >= 90 && p <= 97) pen_fg = pal[p - 82];
      else if (p >= 100 && p <= 107) pen_bg = pal[p - 92];
      i++;
    end
  endfunction

  function automatic void fill_screen();
    put(CMD_FILL, 0, 0, 0, 0, 0, 24'h0, dflt_bg, 1'b0);
    cur_col = 0;
    cur_row = 0;
  endfunction

  function automatic void run_csi(logic [7:0] fin);
    int p0, p1, cnt, cols, rows, mode;
    p0 = param(0, -1);
    p1 = param(1, -1);
    cnt = p0 < 1 ? 1 : p0;
    cols = dim(scr_cols);
    rows = dim(scr_rows);
    mode = p0 < 0 ? 0 : p0;
    case (fin)
      CH_CUU: cur_row = cur_row >= cnt ? cur_row - cnt : 0;
      CH_CUD: begin cur_row += cnt; clamp_cursor(); end
      CH_CUF: begin cur_col += cnt; clamp_cursor(); end
      CH_CUB: cur_col = cur_col >= cnt ? cur_col - cnt : 0;
      CH_CUP, CH_HVP: begin
        cur_row = p0 <= 0 ? 0 : p0 - 1;
        cur_col = p1 <= 0 ? 0 : p1 - 1;
        clamp_cursor();
      end
      CH_ED: begin
        if (mode == 0) put(CMD_ERASE, cur_row, cur_col, rows - 1, cols, CH_SPACE,
                           pen_fg, pen_bg, 1'b0);
        else if (mode == 1) put(CMD_ERASE, 0, 0, cur_row, cur_col + 1, CH_SPACE,
                                pen_fg, pen_bg, 1'b0);
        else fill_screen();
      end
      CH_EL: begin
        if (mode == 0) put(CMD_ERASE, cur_row, cur_col, cur_row, cols, CH_SPACE,
                           pen_fg, pen_bg, 1'b0);
        else if (mode == 1) put(CMD_ERASE, cur_row, 0, cur_row, cur_col + 1, CH_SPACE,
                                pen_fg, pen_bg, 1'b0);
        else put(CMD_ERASE, cur_row, 0, cur_row, cols, CH_SPACE, pen_fg, pen_bg, 1'b0);
      end
      CH_SGR: run_sgr();
      CH_SAVE: begin sav_col = cur_col; sav_row = cur_row; end
      CH_RESTORE: begin cur_row = sav_row; cur_col = sav_col; clamp_cursor(); end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] lighten(logic [7:0] ch);
    return ch > 8'hAA ? 8'hFF : ch + 8'h55;
  endfunction

  function automatic void draw(logic [7:0] c);
    logic [23:0] f, b;
    f = rvs ? pen_bg : pen_fg;
    b = rvs ? pen_fg : pen_bg;
    if (bold) f = {lighten(f[23:16]), lighten(f[15:8]), lighten(f[7:0])};
    put(CMD_GLYPH, cur_row, cur_col, 0, 0, c, f, b, uline);
    cur_col++;
    if (cur_col >= dim(scr_cols)) begin
      cur_col = 0;
      new_line();
    end
  endfunction

  function automatic void take_byte(logic [7:0] c);
    int v;
    case (pstate)
      PS_NORMAL: begin
        if (c == CH_ESC) pstate = PS_ESC;
        else if (c == CH_CR) cur_col = 0;
        else if (c == CH_LF) new_line();
        else if (c == CH_TAB) begin
          cur_col = (cur_col + 8) & ~7;
          if (cur_col >= dim(scr_cols)) begin
            cur_col = 0;
            new_line();
          end
        end else if (c == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else if (c >= CH_SPACE) draw(c);
      end
      PS_ESC: begin
        pstate = PS_NORMAL;
        if (c == CH_LBRACK) begin clear_params(); pstate = PS_CSI; end
        else if (c == CH_7) begin sav_col = cur_col; sav_row = cur_row; end
        else if (c == CH_8) begin cur_row = sav_row; cur_col = sav_col; clamp_cursor(); end
        else if (c == CH_RI) begin
          if (cur_row == 0) put(CMD_CLRTOP, 0, 0, 0, 0, 0, 24'h0, dflt_bg, 1'b0);
          else cur_row--;
        end else if (c == CH_RIS) begin reset_pen(); fill_screen(); end
        else if (c == CH_HASH) pstate = PS_HASH;
        else if (c == CH_LPAREN || c == CH_RPAREN) pstate = PS_CHARSET;
      end
      PS_CSI: begin
        if (c >= CH_0 && c <= CH_9) begin
          if (pcnt < MAX_PARAMS_DEF) begin
            v = prm[pcnt] < 0 ? 0 : prm[pcnt];
            v = v * 10 + (c - CH_0);
            prm[pcnt] = v > 65535 ? 65535 : v;
            pseen = 1;
          end
        end else if (c == CH_SEMI) begin
          if (pcnt < MAX_PARAMS_DEF - 1) pcnt++;
          pseen = 0;
        end else if (c == CH_QUEST || c == CH_GT || c == CH_LT || c == CH_BANG) begin
          // private marker, swallowed
        end else if (c >= CH_FIN_LO && c <= CH_FIN_HI) begin
          if (pseen || pcnt > 0) pcnt++;
          run_csi(c);
          pstate = PS_NORMAL;
        end else pstate = PS_NORMAL;
      end
      default: pstate = PS_NORMAL;
    endcase
  endfunction

  task automatic cmp(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, e, a);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    beats = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      scr_cols = COLS_RST;
      scr_rows = ROWS_RST;
      dflt_fg = DEF_FG_RST;
      dflt_bg = DEF_BG_RST;
      cur_col = 0; cur_row = 0; sav_col = 0; sav_row = 0;
      reset_pen();
      clear_params();
      pstate = PS_NORMAL;
      foreach (pal[i]) pal[i] = 24'h0;
      cmd_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_COLS: begin scr_cols = pwdata[8:0]; clamp_cursor(); end
          REG_ROWS: begin scr_rows = pwdata[8:0]; clamp_cursor(); end
          REG_DEF_FG: dflt_fg = pwdata[23:0];
          REG_DEF_BG: dflt_bg = pwdata[23:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        beats++;
        if (cmd_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual cmd %0d row %0d col %0d",
                   $time, cmd, row, col);
          fails++;
        end else begin
          e = cmd_q.pop_front();
          cmp("cmd", e.cmd, cmd);
          cmp("row", e.row, row);
          cmp("col", e.col, col);
          cmp("end_row", e.end_row, end_row);
          cmp("end_col", e.end_col, end_col);
          cmp("glyph", e.glyph, glyph);
          cmp("fg_color", e.fg_color, fg_color);
          cmp("bg_color", e.bg_color, bg_color);
          cmp("underline_on", e.underline_on, underline_on);
          cmp("last", e.last, last);
        end
      end
      if (in_valid && in_ready) begin
        step_q.delete();
        if (req_type) pal[pal_index] = pal_color;
        else take_byte(data_byte);
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i]) cmd_q.push_back(step_q[i]);
      end
    end
    pending = cmd_q.size();
  end

endmodule

@@ tb/tb_ansi_escape_terminal_parser.sv @@
// testbench top: drives terminal byte streams and register settings, reports the verdict
`timescale 1ns / 100ps
module tb_ansi_escape_terminal_parser;
  import aetp_pkg::*;

  localparam int IDLE_PCT  = 26;
  localparam int DRAIN_LAT = 64;
  localparam int HOLD_LEN  = 300;
  localparam int WDOG_MAX  = 20000;
  localparam int PH_SEQS   = 22;

  logic        clk, rst;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        in_valid, in_ready, req_type;
  logic [7:0]  data_byte;
  logic [3:0]  pal_index;
  logic [23:0] pal_color;
  logic        out_valid, out_ready;
  logic [2:0]  cmd;
  logic [7:0]  row, col, end_row, glyph;
  logic [8:0]  end_col;
  logic [23:0] fg_color, bg_color;
  logic        underline_on, last;
  int          fails, pending, beats;
  bit          calm, hold_req;
  int          items_sent, quiet_cycles;
  logic [7:0]  seq_q[$];

  ansi_escape_terminal_parser i_dut (.*);

  aetp_checker i_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // receiver side: random backpressure plus one long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 0;
      end
      out_ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("timeout: no beat moved for %0d cycles", WDOG_MAX);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel = 1; penable = 0; pwrite = 1; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic settle();
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_LAT) @(negedge clk);
  endtask

  task automatic push_item(bit rt, logic [7:0] b, logic [3:0] idx, logic [23:0] c);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1; req_type = rt; data_byte = b; pal_index = idx; pal_color = c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic flush_seq();
    while (seq_q.size() > 0) push_item(0, seq_q.pop_front(), 4'($urandom), 24'($urandom));
  endtask

  task automatic add_num(int v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) seq_q.push_back(s[i]);
  endtask

  function automatic int rand_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 9);
    if (r < 90) return $urandom_range(0, 300);
    return $urandom_range(65000, 999999);
  endfunction

  task automatic gen_sgr();
    int n, r;
    int codes[] = '{0, 1, 4, 7, 21, 22, 24, 27, 30, 33, 37, 39, 40, 44, 47, 49,
                    90, 93, 97, 100, 105, 107, 2, 55};
    n = ($urandom_range(0, 99) < 4) ? $urandom_range(16, 20) : $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) seq_q.push_back(CH_SEMI);
      r = $urandom_range(0, 99);
      if (r < 5) continue;
      if (r < 25) begin
        add_num(r[0] ? 38 : 48);
        seq_q.push_back(CH_SEMI);
        if (r < 15) begin
          add_num(5);
          if (r != 6) begin seq_q.push_back(CH_SEMI); add_num($urandom_range(0, 300)); end
        end else begin
          add_num(2);
          for (int k = 0; k < $urandom_range(1, 3); k++) begin
            seq_q.push_back(CH_SEMI);
            add_num($urandom_range(0, 300));
          end
        end
      end else add_num(codes[$urandom_range(0, codes.size() - 1)]);
    end
    seq_q.push_back(CH_SGR);
  endtask

  task automatic gen_csi();
    int r, n;
    logic [7:0] fins[] = '{CH_CUU, CH_CUD, CH_CUF, CH_CUB, CH_CUP, CH_HVP, CH_ED,
                            CH_EL, CH_SAVE, CH_RESTORE};
    logic [7:0] marks[] = '{CH_QUEST, CH_GT, CH_LT, CH_BANG};
    seq_q.push_back(CH_ESC);
    seq_q.push_back(CH_LBRACK);
    if ($urandom_range(0, 99) < 8) seq_q.push_back(marks[$urandom_range(0, 3)]);
    r = $urandom_range(0, 99);
    if (r < 35) begin
      gen_sgr();
    end else if (r < 90) begin
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        if (i > 0) seq_q.push_back(CH_SEMI);
        if ($urandom_range(0, 9) != 0) add_num(rand_param());
      end
      seq_q.push_back(fins[$urandom_range(0, fins.size() - 1)]);
    end else if (r < 95) begin
      add_num(rand_param());
      seq_q.push_back(8'($urandom_range(CH_FIN_LO, CH_FIN_HI)));
    end else begin
      // broken sequence: a stray byte aborts it, unless it is the 0x21 private marker
      add_num(rand_param());
      seq_q.push_back(r[0] ? CH_ESC : 8'($urandom_range(0, 8'h2F)));
    end
  endtask

  task automatic gen_random_seq();
    int r;
    logic [7:0] ctl[] = '{CH_CR, CH_LF, CH_TAB, CH_BS};
    logic [7:0] escs[] = '{CH_7, CH_8, CH_RI, CH_RI, CH_RIS, CH_HASH, CH_LPAREN, CH_RPAREN};
    r = $urandom_range(0, 99);
    if (r < 30) begin
      for (int i = 0; i < $urandom_range(1, 6); i++)
        seq_q.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(8'h7F, 8'hFF))
                                                    : 8'($urandom_range(CH_SPACE, CH_FIN_HI)));
    end else if (r < 42) begin
      seq_q.push_back((r < 40) ? ctl[$urandom_range(0, 3)] : 8'($urandom_range(0, 8'h1F)));
    end else if (r < 78) begin
      gen_csi();
    end else if (r < 90) begin
      seq_q.push_back(CH_ESC);
      seq_q.push_back((r < 88) ? escs[$urandom_range(0, escs.size() - 1)] : 8'($urandom));
      if ($urandom_range(0, 1)) seq_q.push_back(8'($urandom));
    end else if (r < 95) begin
      flush_seq();
      push_item(1, 8'($urandom), 4'($urandom), 24'($urandom));
    end else begin
      seq_q.push_back(8'($urandom));
    end
    flush_seq();
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) seq_q.push_back(s[i]);
    flush_seq();
  endtask

  initial begin
    logic [8:0]  ph_cols[6] = '{9'd80, 9'd1, 9'd256, 9'd7, 9'd0, 9'd300};
    logic [8:0]  ph_rows[6] = '{9'd3, 9'd256, 9'd1, 9'd5, 9'd300, 9'd0};
    logic [23:0] ph_fg[6]   = '{24'hFFFFFF, 24'h000000, 24'h123456, 24'hAB55AA,
                                24'hFFFFFF, 24'h808080};
    logic [23:0] ph_bg[6]   = '{24'h000000, 24'hFFFFFF, 24'h654321, 24'h00FF00,
                                24'hFFFFFF, 24'h0000AB};
    rst = 1; calm = 0; hold_req = 0; items_sent = 0; quiet_cycles = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; req_type = 0; data_byte = 0; pal_index = 0; pal_color = 0;
    repeat (12) @(negedge clk);
    rst = 0;
    @(negedge clk);
    reg_write(REG_COLS, 32'd80);
    reg_write(REG_ROWS, 32'd25);
    reg_write(REG_DEF_FG, 32'h00AAAAAA);
    reg_write(REG_DEF_BG, 32'h00000000);

    // palette fully loaded before any colour lookup
    for (int i = 0; i < 16; i++)
      push_item(1, 8'($urandom), i[3:0],
                (i == 0) ? 24'h0 : (i == 15) ? 24'hFFFFFF : 24'($urandom));
    seq_q = '{8'h41, 8'hFF, 8'h7F, CH_TAB, CH_BS, CH_CR, CH_LF, 8'h01, CH_ESC, CH_RI};
    flush_seq();
    send_str("\033[1;4;7mX\033[38;2;300;0;255;48;5;999mY\033[2J\033[9K");
    send_str("\033[99999;1;2;3;4;5;6;7;8;9;1;2;3;4;5;6;7;8H\033[5J\033cZ");

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      reg_write(REG_COLS, 32'(ph_cols[ph]));
      reg_write(REG_ROWS, 32'(ph_rows[ph]));
      reg_write(REG_DEF_FG, 32'(ph_fg[ph]));
      reg_write(REG_DEF_BG, 32'(ph_bg[ph]));
      calm = (ph == 1);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < PH_SEQS; k++) begin
        if (ph == 3 && k == PH_SEQS / 2) begin
          in_valid = 0;
          while (pending != 0) @(negedge clk);
        end
        gen_random_seq();
      end
    end
    calm = 0;
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_LAT) @(negedge clk);

    $display("sent %0d items over 6 screen settings, %0d command beats checked",
             items_sent, beats);
    $display("covered text, controls, csi moves, erases, sgr colour forms and escapes");
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
